>>> src/sct_pkg.sv
// shared types and widths for the segment crossing test
package sct_pkg;

  // coordinate width and the widths that follow from it
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  // number of orientation tests per item
  localparam int N_ORIENT = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  // sign of one cross product
  typedef struct packed {
    logic pos;
    logic neg;
  } orient_t;

endpackage : sct_pkg

>>> src/segment_crossing_test.sv
// segment crossing test: four-stage pipeline of exact cross products
// out_valid is v4_r: start passes through v1_r, v2_r, v3_r and v4_r, alongside the payload up to crosses_r
// throughput: one item per cycle, set by the 4-stage multiply and compare pipeline
// busy stays low: the pipeline never stalls and the receiver cannot hold results off
// reset (rst_n low, synchronous) clears the valid bits; payload registers are not reset
module segment_crossing_test (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sct_pkg::coord_t in_p_first_x,
  input  sct_pkg::coord_t in_p_first_y,
  input  sct_pkg::coord_t in_p_second_x,
  input  sct_pkg::coord_t in_p_second_y,
  input  sct_pkg::coord_t in_q_first_x,
  input  sct_pkg::coord_t in_q_first_y,
  input  sct_pkg::coord_t in_q_second_x,
  input  sct_pkg::coord_t in_q_second_y,
  output logic           out_valid,
  output logic           out_crosses
);
  import sct_pkg::*;

  // stage 1: differences, endpoint flags, collinear extents
  diff_t   la_nxt [N_ORIENT];
  diff_t   lb_nxt [N_ORIENT];
  diff_t   ra_nxt [N_ORIENT];
  diff_t   rb_nxt [N_ORIENT];
  diff_t   la_r   [N_ORIENT];
  diff_t   lb_r   [N_ORIENT];
  diff_t   ra_r   [N_ORIENT];
  diff_t   rb_r   [N_ORIENT];
  logic    reject_nxt, reject1_r;
  coord_t  pa_nxt, pb_nxt, qa_nxt, qb_nxt;
  coord_t  pa_r, pb_r, qa_r, qb_r;
  logic    v1_r;

  // stage 2: products and overlap flag
  prod_t   pl_r [N_ORIENT];
  prod_t   pr_r [N_ORIENT];
  logic    overlap_nxt, overlap2_r, reject2_r;
  logic    v2_r;

  // stage 3: orientation signs
  orient_t dir_nxt [N_ORIENT];
  orient_t dir_r   [N_ORIENT];
  logic    overlap3_r, reject3_r;
  logic    v3_r;

  // stage 4: result
  logic    crosses_nxt, crosses_r;
  logic    v4_r;

  logic    accept;
  logic    eq_p1q1, eq_p1q2, eq_p2q1, eq_p2q2, eq_p1p2, eq_q1q2;
  coord_t  pmin, pmax, qmin, qmax, lo, hi;
  logic    collinear, opp_p, opp_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // endpoint equality and the early reject
  always_comb begin
    eq_p1q1 = (in_p_first_x == in_q_first_x) && (in_p_first_y == in_q_first_y);
    eq_p1q2 = (in_p_first_x == in_q_second_x) && (in_p_first_y == in_q_second_y);
    eq_p2q1 = (in_p_second_x == in_q_first_x) && (in_p_second_y == in_q_first_y);
    eq_p2q2 = (in_p_second_x == in_q_second_x) && (in_p_second_y == in_q_second_y);
    eq_p1p2 = (in_p_first_x == in_p_second_x) && (in_p_first_y == in_p_second_y);
    eq_q1q2 = (in_q_first_x == in_q_second_x) && (in_q_first_y == in_q_second_y);
    reject_nxt = ((eq_p1q1 | eq_p1q2 | eq_p2q1 | eq_p2q2) &
                  ~((eq_p1q1 & eq_p2q2) | (eq_p1q2 & eq_p2q1)))
                 | eq_p1p2 | eq_q1q2;
  end

  // cross product operands: orient(a,b,c) = (b-a).x*(c-a).y vs (b-a).y*(c-a).x
  always_comb begin
    // p1, p2 against q1
    la_nxt[0] = diff_t'(in_p_second_x) - diff_t'(in_p_first_x);
    lb_nxt[0] = diff_t'(in_q_first_y)  - diff_t'(in_p_first_y);
    ra_nxt[0] = diff_t'(in_p_second_y) - diff_t'(in_p_first_y);
    rb_nxt[0] = diff_t'(in_q_first_x)  - diff_t'(in_p_first_x);
    // p1, p2 against q2
    la_nxt[1] = diff_t'(in_p_second_x) - diff_t'(in_p_first_x);
    lb_nxt[1] = diff_t'(in_q_second_y) - diff_t'(in_p_first_y);
    ra_nxt[1] = diff_t'(in_p_second_y) - diff_t'(in_p_first_y);
    rb_nxt[1] = diff_t'(in_q_second_x) - diff_t'(in_p_first_x);
    // q1, q2 against p1
    la_nxt[2] = diff_t'(in_q_second_x) - diff_t'(in_q_first_x);
    lb_nxt[2] = diff_t'(in_p_first_y)  - diff_t'(in_q_first_y);
    ra_nxt[2] = diff_t'(in_q_second_y) - diff_t'(in_q_first_y);
    rb_nxt[2] = diff_t'(in_p_first_x)  - diff_t'(in_q_first_x);
    // q1, q2 against p2
    la_nxt[3] = diff_t'(in_q_second_x) - diff_t'(in_q_first_x);
    lb_nxt[3] = diff_t'(in_p_second_y) - diff_t'(in_q_first_y);
    ra_nxt[3] = diff_t'(in_q_second_y) - diff_t'(in_q_first_y);
    rb_nxt[3] = diff_t'(in_p_second_x) - diff_t'(in_q_first_x);
  end

  // collinear extents along x, or along y when p is vertical
  always_comb begin
    if (in_p_first_x != in_p_second_x) begin
      pa_nxt = in_p_first_x;
      pb_nxt = in_p_second_x;
      qa_nxt = in_q_first_x;
      qb_nxt = in_q_second_x;
    end else begin
      pa_nxt = in_p_first_y;
      pb_nxt = in_p_second_y;
      qa_nxt = in_q_first_y;
      qb_nxt = in_q_second_y;
    end
  end

  // overlap of the two extents over a positive length
  always_comb begin
    pmin = (pa_r < pb_r) ? pa_r : pb_r;
    pmax = (pa_r > pb_r) ? pa_r : pb_r;
    qmin = (qa_r < qb_r) ? qa_r : qb_r;
    qmax = (qa_r > qb_r) ? qa_r : qb_r;
    lo   = (pmin > qmin) ? pmin : qmin;
    hi   = (pmax < qmax) ? pmax : qmax;
    overlap_nxt = hi > lo;
  end

  // orientation signs from comparing the two products
  always_comb begin
    for (int i = 0; i < N_ORIENT; i++) begin
      dir_nxt[i].pos = pl_r[i] > pr_r[i];
      dir_nxt[i].neg = pl_r[i] < pr_r[i];
    end
  end

  // final decision
  always_comb begin
    collinear = ~dir_r[0].pos & ~dir_r[0].neg & ~dir_r[1].pos & ~dir_r[1].neg;
    opp_p     = (dir_r[0].pos & dir_r[1].neg) | (dir_r[0].neg & dir_r[1].pos);
    opp_q     = (dir_r[2].pos & dir_r[3].neg) | (dir_r[2].neg & dir_r[3].pos);
    if (reject3_r) begin
      crosses_nxt = 1'b0;
    end else if (collinear) begin
      crosses_nxt = overlap3_r;
    end else begin
      crosses_nxt = opp_p & opp_q;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    la_r      <= la_nxt;
    lb_r      <= lb_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    reject1_r <= reject_nxt;
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    qa_r      <= qa_nxt;
    qb_r      <= qb_nxt;
    for (int i = 0; i < N_ORIENT; i++) begin
      pl_r[i] <= prod_t'(la_r[i]) * prod_t'(lb_r[i]);
      pr_r[i] <= prod_t'(ra_r[i]) * prod_t'(rb_r[i]);
    end
    overlap2_r <= overlap_nxt;
    reject2_r  <= reject1_r;
    dir_r      <= dir_nxt;
    overlap3_r <= overlap2_r;
    reject3_r  <= reject2_r;
    crosses_r  <= crosses_nxt;
  end

  assign out_valid   = v4_r;
  assign out_crosses = crosses_r;

endmodule : segment_crossing_test
